// ===== design/mkd_pkg.sv =====
// Shared types, constants and the Morse symbol lookup for the key decoder.
// No dependencies; the decoder, register file, core and output buffer import this package.
`default_nettype none

package mkd_pkg;

    // Width of one configuration register and of its index on the write port
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 8;

    // Element buffer: marker bit followed by up to five elements
    localparam int            MAX_ELEMENTS = 5;
    localparam int            ELEM_CODE_W  = MAX_ELEMENTS + 1;
    localparam int            ELEM_TOTAL_W = 3;
    localparam logic [ELEM_TOTAL_W-1:0] ELEM_LIMIT = ELEM_TOTAL_W'(MAX_ELEMENTS);
    localparam logic [ELEM_CODE_W-1:0]  CODE_EMPTY = ELEM_CODE_W'(1);

    localparam int CHAR_W = 7;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DOT_MIN  = 8'd0,
        CFG_DOT_MAX  = 8'd1,
        CFG_DASH_MAX = 8'd2,
        CFG_GAP      = 8'd3
    } t_cfg_index;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] DOT_MIN_RESET  = 16'd1875;
    localparam logic [CFG_DATA_W-1:0] DOT_MAX_RESET  = 16'd12500;
    localparam logic [CFG_DATA_W-1:0] DASH_MAX_RESET = 16'd25000;
    localparam logic [CFG_DATA_W-1:0] GAP_RESET      = 16'd30000;

    // Result event kinds
    typedef enum logic [1:0] {
        KIND_DOT   = 2'd0,
        KIND_DASH  = 2'd1,
        KIND_CHAR  = 2'd2,
        KIND_UNREC = 2'd3
    } t_kind;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] dot_min;
        logic [CFG_DATA_W-1:0] dot_max;
        logic [CFG_DATA_W-1:0] dash_max;
        logic [CFG_DATA_W-1:0] gap;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] char_code;
    } t_result;

    // Map a marker-prefixed element code (dot 0, dash 1) to ASCII, 0 if none
    function automatic logic [CHAR_W-1:0] mkd_lookup(input logic [ELEM_CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            6'd2:    ch = 7'h45; // E
            6'd3:    ch = 7'h54; // T
            6'd4:    ch = 7'h49; // I
            6'd5:    ch = 7'h41; // A
            6'd6:    ch = 7'h4E; // N
            6'd7:    ch = 7'h4D; // M
            6'd8:    ch = 7'h53; // S
            6'd9:    ch = 7'h55; // U
            6'd10:   ch = 7'h52; // R
            6'd11:   ch = 7'h57; // W
            6'd12:   ch = 7'h44; // D
            6'd13:   ch = 7'h4B; // K
            6'd14:   ch = 7'h47; // G
            6'd15:   ch = 7'h4F; // O
            6'd16:   ch = 7'h48; // H
            6'd17:   ch = 7'h56; // V
            6'd18:   ch = 7'h46; // F
            6'd20:   ch = 7'h4C; // L
            6'd22:   ch = 7'h50; // P
            6'd23:   ch = 7'h4A; // J
            6'd24:   ch = 7'h42; // B
            6'd25:   ch = 7'h58; // X
            6'd26:   ch = 7'h43; // C
            6'd27:   ch = 7'h59; // Y
            6'd28:   ch = 7'h5A; // Z
            6'd29:   ch = 7'h51; // Q
            6'd32:   ch = 7'h35; // 5
            6'd33:   ch = 7'h34; // 4
            6'd35:   ch = 7'h33; // 3
            6'd39:   ch = 7'h32; // 2
            6'd47:   ch = 7'h31; // 1
            6'd48:   ch = 7'h36; // 6
            6'd56:   ch = 7'h37; // 7
            6'd60:   ch = 7'h38; // 8
            6'd62:   ch = 7'h39; // 9
            6'd63:   ch = 7'h30; // 0
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== design/mkd_ifs.sv =====
// Channel interfaces of the key decoder: key samples, events, register writes.
// No package import; payload widths are written as literals that match mkd_pkg.
`default_nettype none

interface mkd_key_if;
    logic valid;
    logic ready;
    logic key_pressed;

    modport source (output valid, output key_pressed, input ready);
    modport sink   (input valid, input key_pressed, output ready);
endinterface

interface mkd_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [6:0] char_code;

    modport source (output valid, output event_kind, output char_code, input ready);
    modport sink   (input valid, input event_kind, input char_code, output ready);
endinterface

interface mkd_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/morse_key_decoder.sv =====
// Morse key decoder: one key sample per beat, dot/dash and character events out.
// An event is registered in the output register, or in the skid stage while that one is held.
// Throughput: one sample per cycle; input stalls only while two events wait at the output
// (output register plus skid stage). Register writes are taken in every cycle.
// Reset (synchronous, active low) clears counters and element buffer and restores the
// default thresholds; pending events are dropped.
`default_nettype none

module morse_key_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mkd_key_if.sink        i_key_ch,
    mkd_cfg_if.sink        i_cfg_ch,
    mkd_evt_if.source      o_evt_ch
);
    import mkd_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    t_result out_res;
    logic    core_push;
    logic    can_push;
    logic    accept;

    assign i_cfg_ch.ready = 1'b1;
    assign i_key_ch.ready = can_push;
    assign accept         = i_key_ch.valid && can_push;

    // Threshold registers
    mkd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_ch.valid),
        .i_index (i_cfg_ch.index),
        .i_data  (i_cfg_ch.data),
        .o_cfg   (cfg)
    );

    // Keying state and event generation
    mkd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_key    (i_key_ch.key_pressed),
        .i_cfg    (cfg),
        .o_push   (core_push),
        .o_result (core_res)
    );

    // Event register and skid
    mkd_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (core_push),
        .i_data     (core_res),
        .o_can_push (can_push),
        .o_valid    (o_evt_ch.valid),
        .o_data     (out_res),
        .i_ready    (o_evt_ch.ready)
    );

    assign o_evt_ch.event_kind = out_res.kind;
    assign o_evt_ch.char_code  = out_res.char_code;

`ifndef NO_ASSERTIONS
    // Input stalls only when the output register is also full
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_key_ch.ready |-> o_evt_ch.valid)
        else $error("input stalled with empty output register");

    // Only a decoded character carries a code, and it is never zero
    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_ch.valid |-> ((o_evt_ch.event_kind == KIND_CHAR) == (o_evt_ch.char_code != '0)))
        else $error("char_code does not match event kind");

    // An empty output register is never followed by an input stall
    a_no_stall_after_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_evt_ch.valid |=> i_key_ch.ready)
        else $error("stall after an empty output register");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_evt_ch.valid)
        else $error("event valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== design/mkd_cfg_regs.sv =====
// Configuration register file of the key decoder (four 16-bit thresholds).
// Depends on mkd_pkg.
`default_nettype none

module mkd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [mkd_pkg::CFG_INDEX_W-1:0]  i_index,
    input  logic [mkd_pkg::CFG_DATA_W-1:0]   i_data,
    output mkd_pkg::t_cfg                    o_cfg
);
    import mkd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write index; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                CFG_DOT_MIN:  n_cfg.dot_min  = i_data;
                CFG_DOT_MAX:  n_cfg.dot_max  = i_data;
                CFG_DASH_MAX: n_cfg.dash_max = i_data;
                CFG_GAP:      n_cfg.gap      = i_data;
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_min  <= DOT_MIN_RESET;
            r_cfg.dot_max  <= DOT_MAX_RESET;
            r_cfg.dash_max <= DASH_MAX_RESET;
            r_cfg.gap      <= GAP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/mkd_core.sv =====
// Keying state of the decoder: press/idle counters, element buffer, classification
// and character lookup. Produces at most one event per accepted sample. Uses mkd_pkg.
`default_nettype none

module mkd_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_key,
    input  mkd_pkg::t_cfg     i_cfg,
    output logic              o_push,
    output mkd_pkg::t_result  o_result
);
    import mkd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    logic                    r_key_prev, n_key_prev;
    logic [COUNT_WIDTH-1:0]  r_press,    n_press;
    logic [COUNT_WIDTH-1:0]  r_idle,     n_idle;
    logic [ELEM_CODE_W-1:0]  r_code,     n_code;
    logic [ELEM_TOTAL_W-1:0] r_total,    n_total;
    logic                    r_overlong, n_overlong;

    logic [COUNT_WIDTH-1:0] dot_min, dot_max, dash_max, gap;
    logic [COUNT_WIDTH-1:0] press_inc, idle_inc;
    logic                   is_dot, is_dash;
    logic [CHAR_W-1:0]      ch;

    // Widen thresholds to the counter width
    assign dot_min  = COUNT_WIDTH'(i_cfg.dot_min);
    assign dot_max  = COUNT_WIDTH'(i_cfg.dot_max);
    assign dash_max = COUNT_WIDTH'(i_cfg.dash_max);
    assign gap      = COUNT_WIDTH'(i_cfg.gap);

    // Saturating increments
    assign press_inc = (r_press == CountMax) ? r_press : r_press + 1'b1;
    assign idle_inc  = (r_idle == CountMax) ? r_idle : r_idle + 1'b1;

    // Classify the finished press; dot test wins on overlap
    assign is_dot  = (r_press >= dot_min) && (r_press <= dot_max);
    assign is_dash = !is_dot && (r_press > dot_max) && (r_press <= dash_max);

    // Look up the buffered pattern; a sixth element spoils it
    assign ch = r_overlong ? '0 : mkd_lookup(r_code);

    always_comb begin
        n_key_prev = r_key_prev;
        n_press    = r_press;
        n_idle     = r_idle;
        n_code     = r_code;
        n_total    = r_total;
        n_overlong = r_overlong;
        o_push     = 1'b0;
        o_result   = '{kind: KIND_DOT, char_code: '0};

        if (i_accept) begin
            n_key_prev = i_key;
            priority if (i_key) begin
                // key held: count the press
                n_press = press_inc;
                n_idle  = '0;
            end else if (r_key_prev) begin
                // release: emit and store the element
                n_press = '0;
                n_idle  = '0;
                if (is_dot || is_dash) begin
                    o_push   = 1'b1;
                    o_result = '{kind: (is_dash ? KIND_DASH : KIND_DOT), char_code: '0};
                    if (r_total < ELEM_LIMIT) begin
                        n_code  = {r_code[ELEM_CODE_W-2:0], is_dash};
                        n_total = r_total + 1'b1;
                    end else begin
                        n_overlong = 1'b1;
                    end
                end
            end else begin
                // idle: end the character once the gap is reached
                n_idle = idle_inc;
                if ((r_total != '0) && (idle_inc >= gap)) begin
                    o_push = 1'b1;
                    if (ch != '0) begin
                        o_result = '{kind: KIND_CHAR, char_code: ch};
                    end else begin
                        o_result = '{kind: KIND_UNREC, char_code: '0};
                    end
                    n_code     = CODE_EMPTY;
                    n_total    = '0;
                    n_overlong = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_prev <= 1'b0;
            r_press    <= '0;
            r_idle     <= '0;
            r_code     <= CODE_EMPTY;
            r_total    <= '0;
            r_overlong <= 1'b0;
        end else begin
            r_key_prev <= n_key_prev;
            r_press    <= n_press;
            r_idle     <= n_idle;
            r_code     <= n_code;
            r_total    <= n_total;
            r_overlong <= n_overlong;
        end
    end

endmodule

`default_nettype wire

// ===== design/mkd_out_buf.sv =====
// Event output register with a skid stage, so a waiting event does not stall input.
// Depends on mkd_pkg for the event type.
`default_nettype none

module mkd_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mkd_pkg::t_result  i_data,
    output logic              o_can_push,
    output logic              o_valid,
    output mkd_pkg::t_result  o_data,
    input  logic              i_ready
);
    import mkd_pkg::*;

    logic    r_main_v, n_main_v;
    logic    r_skid_v, n_skid_v;
    t_result r_main,   n_main;
    t_result r_skid,   n_skid;
    logic    pop;

    assign pop = r_main_v && i_ready;

    // Refill the output register from skid first, else from the new event
    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        if (!r_main_v || pop) begin
            if (r_skid_v) begin
                n_main   = r_skid;
                n_main_v = 1'b1;
                n_skid_v = 1'b0;
            end else begin
                n_main   = i_data;
                n_main_v = i_push;
            end
        end else if (i_push) begin
            n_skid   = i_data;
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_can_push = !r_skid_v;
    assign o_valid    = r_main_v;
    assign o_data     = r_main;

endmodule

`default_nettype wire

// ===== bench/tb_morse_key_decoder.sv =====
`timescale 1ns / 100ps
// Self-checking bench for morse_key_decoder: directed key runs, then random keying.
// Depends on mkd_pkg, the channel interfaces and the decoder RTL.

module tb_morse_key_decoder;
    import mkd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SPARE_INDEX    = 4;     // first index that maps to no register
    localparam int PHASES         = 7;
    localparam int PHASE_SAMPLES  = 70;
    localparam int PLAN_ROWS      = 38;

    typedef enum logic [1:0] {
        ROW_IDLE,
        ROW_PRESS,
        ROW_CFG
    } t_row_op;

    // PRESS: arg ticks down, then one release tick; IDLE: arg ticks up; CFG: arg index
    typedef struct packed {
        t_row_op     op;
        logic [31:0] arg;
        logic [15:0] val;
        logic        typed;
        t_kind       kind;
        logic [7:0]  ch;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mkd_key_if key_ch ();
    mkd_cfg_if cfg_ch ();
    mkd_evt_if evt_ch ();

    morse_key_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key_ch (key_ch),
        .i_cfg_ch (cfg_ch),
        .o_evt_ch (evt_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Keyer mirror: thresholds, counters and the pending element pattern
    t_cfg        shadow_cfg = '{DOT_MIN_RESET, DOT_MAX_RESET, DASH_MAX_RESET, GAP_RESET};
    logic        key_was_down = 1'b0;
    logic [15:0] press_ticks = '0;
    logic [15:0] idle_ticks = '0;
    string       pattern = "";
    logic        pattern_overrun = 1'b0;
    t_result     expected_events [$];

    // Directed rows may carry a hand-written event that replaces the mirror's one
    logic        row_typed = 1'b0;
    t_result     row_result;

    int          mismatches = 0;
    int          sent_samples = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    bit          calm = 1'b0;

    string morse_codes [36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };
    string morse_glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

    t_row plan [PLAN_ROWS] = '{
        // reset thresholds: idle and a very short press give nothing
        '{ROW_IDLE,  3,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_PRESS, 1,     16'd0,     1'b0, KIND_DOT,   8'd0},
        // short thresholds: class edges, overlong and unmatched patterns
        '{ROW_CFG,   32'(CFG_DOT_MIN),  16'd2, 1'b0, KIND_DOT, 8'd0},
        '{ROW_CFG,   32'(CFG_DOT_MAX),  16'd4, 1'b0, KIND_DOT, 8'd0},
        '{ROW_CFG,   32'(CFG_DASH_MAX), 16'd8, 1'b0, KIND_DOT, 8'd0},
        '{ROW_CFG,   32'(CFG_GAP),      16'd6, 1'b0, KIND_DOT, 8'd0},
        '{ROW_PRESS, 1,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_PRESS, 4,     16'd0,     1'b1, KIND_DOT,   8'd0},
        '{ROW_PRESS, 5,     16'd0,     1'b1, KIND_DASH,  8'd0},
        '{ROW_PRESS, 8,     16'd0,     1'b1, KIND_DASH,  8'd0},
        '{ROW_PRESS, 9,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_IDLE,  6,     16'd0,     1'b1, KIND_CHAR,  "W"},
        '{ROW_PRESS, 2,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_PRESS, 2,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_PRESS, 2,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_PRESS, 2,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_PRESS, 2,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_PRESS, 2,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_IDLE,  6,     16'd0,     1'b1, KIND_UNREC, 8'd0},
        '{ROW_PRESS, 2,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_PRESS, 2,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_PRESS, 6,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_PRESS, 6,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_IDLE,  6,     16'd0,     1'b1, KIND_UNREC, 8'd0},
        // unused index, zero gap
        '{ROW_CFG,   SPARE_INDEX,       16'hFFFF, 1'b0, KIND_DOT, 8'd0},
        '{ROW_CFG,   32'(CFG_GAP),      16'd0,    1'b0, KIND_DOT, 8'd0},
        '{ROW_PRESS, 3,     16'd0,     1'b1, KIND_DOT,   8'd0},
        '{ROW_IDLE,  1,     16'd0,     1'b1, KIND_CHAR,  "E"},
        // dot minimum above the dash window
        '{ROW_CFG,   32'(CFG_DOT_MIN),  16'd10, 1'b0, KIND_DOT, 8'd0},
        '{ROW_PRESS, 5,     16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_PRESS, 10,    16'd0,     1'b0, KIND_DOT,   8'd0},
        '{ROW_IDLE,  1,     16'd0,     1'b0, KIND_DOT,   8'd0},
        // empty dot window, full-scale dash window
        '{ROW_CFG,   32'(CFG_DOT_MIN),  16'd0,    1'b0, KIND_DOT, 8'd0},
        '{ROW_CFG,   32'(CFG_DOT_MAX),  16'd0,    1'b0, KIND_DOT, 8'd0},
        '{ROW_CFG,   32'(CFG_DASH_MAX), 16'hFFFF, 1'b0, KIND_DOT, 8'd0},
        '{ROW_CFG,   32'(CFG_GAP),      16'd1,    1'b0, KIND_DOT, 8'd0},
        '{ROW_PRESS, 9,     16'd0,     1'b1, KIND_DASH,  8'd0},
        '{ROW_IDLE,  1,     16'd0,     1'b1, KIND_CHAR,  "T"}
    };

    function automatic logic [6:0] letter_for(string pat);
        byte g;
        for (int i = 0; i < 36; i++) begin
            if (morse_codes[i] == pat) begin
                g = morse_glyphs[i];
                return g[6:0];
            end
        end
        return 7'd0;
    endfunction

    function automatic void post_event(t_kind kind, logic [6:0] ch);
        t_result r;
        r.kind = kind;
        r.char_code = ch;
        if (row_typed) begin
            r = row_result;
            row_typed = 1'b0;
        end
        expected_events.push_back(r);
    endfunction

    function automatic void add_element(string mark);
        if (pattern.len() < MAX_ELEMENTS) pattern = {pattern, mark};
        else pattern_overrun = 1'b1;
    endfunction

    // Advance the keyer mirror by one sample, queueing any event it causes
    function automatic void keyer_tick(logic key);
        logic [6:0] held;
        if (key) begin
            if (press_ticks != '1) press_ticks++;
            idle_ticks = '0;
        end else if (key_was_down) begin
            if (press_ticks >= shadow_cfg.dot_min && press_ticks <= shadow_cfg.dot_max) begin
                add_element(".");
                post_event(KIND_DOT, 7'd0);
            end else if (press_ticks > shadow_cfg.dot_max &&
                         press_ticks <= shadow_cfg.dash_max) begin
                add_element("-");
                post_event(KIND_DASH, 7'd0);
            end
            press_ticks = '0;
            idle_ticks = '0;
        end else begin
            if (idle_ticks != '1) idle_ticks++;
            if (pattern.len() > 0 && idle_ticks >= shadow_cfg.gap) begin
                held = pattern_overrun ? 7'd0 : letter_for(pattern);
                if (held != 7'd0) post_event(KIND_CHAR, held);
                else post_event(KIND_UNREC, 7'd0);
                pattern = "";
                pattern_overrun = 1'b0;
            end
        end
        key_was_down = key;
    endfunction

    // Sample all channels at the rising edge: mirror writes and samples, check events
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_DOT_MIN:  shadow_cfg.dot_min = cfg_ch.data;
                    CFG_DOT_MAX:  shadow_cfg.dot_max = cfg_ch.data;
                    CFG_DASH_MAX: shadow_cfg.dash_max = cfg_ch.data;
                    CFG_GAP:      shadow_cfg.gap = cfg_ch.data;
                    default: ;
                endcase
            end
            if (key_ch.valid && key_ch.ready) keyer_tick(key_ch.key_pressed);
            if (evt_ch.valid && evt_ch.ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, expected none, got kind %0d char %02h",
                             $time, evt_ch.event_kind, evt_ch.char_code);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    if (evt_ch.event_kind !== want.kind ||
                        evt_ch.char_code !== want.char_code) begin
                        $display("%0t: event mismatch, expected kind %0d char %02h, got kind %0d char %02h",
                                 $time, want.kind, want.char_code,
                                 evt_ch.event_kind, evt_ch.char_code);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run after a long stretch with no beat on any channel
    always @(posedge i_clk) begin
        if ((key_ch.valid && key_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (evt_ch.valid && evt_ch.ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Event sink: drop ready in random bursts unless the run is calm
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            evt_ch.ready <= 1'b0;
        end else if (stalls_on && !calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            evt_ch.ready <= 1'b0;
        end else begin
            evt_ch.ready <= 1'b1;
        end
    end

    // Send one key sample, with an optional hold-off burst first; valid stays high after
    task automatic send_key(input logic level);
        if (gaps_on && !calm && $urandom_range(0, 9) == 0) begin
            key_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.key_pressed <= level;
        @(posedge i_clk);
        while (!key_ch.ready) @(posedge i_clk);
        sent_samples++;
        @(negedge i_clk);
    endtask

    task automatic press_and_release(input int ticks);
        repeat (ticks) send_key(1'b1);
        send_key(1'b0);
    endtask

    // Hold the key channel until every event is out, then let the pipe settle
    task automatic drain_events();
        key_ch.valid <= 1'b0;
        while (expected_events.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Leaves the write valid high; the caller drops it after the last write
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic int press_length(bit want_dash);
        int lo;
        int hi;
        if (want_dash) begin
            lo = int'(shadow_cfg.dot_max) + 1;
            hi = int'(shadow_cfg.dash_max);
        end else begin
            lo = int'(shadow_cfg.dot_min);
            hi = int'(shadow_cfg.dot_max);
        end
        if (lo < 1) lo = 1;
        if (hi > lo + 10) hi = lo + 10;
        if (lo > hi) return $urandom_range(1, 8);
        return $urandom_range(lo, hi);
    endfunction

    // Key a whole character: elements spaced below the gap, then a full gap
    task automatic send_letter();
        int elems;
        int gap;
        int space;
        gap = int'(shadow_cfg.gap);
        elems = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
        for (int e = 0; e < elems; e++) begin
            press_and_release(press_length($urandom_range(0, 1)));
            if (e != elems - 1) begin
                space = (gap > 1) ? $urandom_range(0, gap - 1) : 0;
                repeat (space) send_key(1'b0);
            end
        end
        repeat (gap + $urandom_range(0, 3)) send_key(1'b0);
    endtask

    // Random key levels in random runs
    task automatic send_noise();
        logic level;
        repeat ($urandom_range(1, 6)) begin
            level = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 12)) send_key(level);
        end
    endtask

    initial begin
        t_row        row;
        int          phase_start;
        logic [15:0] dmin;
        logic [15:0] dmax;
        logic [15:0] dsh;
        logic [15:0] gap;
        logic [7:0]  spare;

        i_rst_n = 1'b0;
        key_ch.valid = 1'b0;
        key_ch.key_pressed = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        evt_ch.ready = 1'b1;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table
        for (int i = 0; i < PLAN_ROWS; i++) begin
            row = plan[i];
            if (row.op == ROW_CFG) begin
                if (i == 0 || plan[i-1].op != ROW_CFG) drain_events();
                write_reg(row.arg[7:0], row.val);
            end else begin
                if (i > 0 && plan[i-1].op == ROW_CFG) cfg_ch.valid <= 1'b0;
                row_typed = row.typed;
                row_result.kind = row.kind;
                row_result.char_code = row.ch[6:0];
                if (row.op == ROW_PRESS) press_and_release(int'(row.arg));
                else repeat (int'(row.arg)) send_key(1'b0);
                if (row_typed) begin
                    $display("%0t: expected kind %0d char %02h, got no event",
                             $time, row_result.kind, row_result.char_code);
                    mismatches++;
                    row_typed = 1'b0;
                end
            end
        end

        // Random phases, each under its own thresholds
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_events();
            if (ph == 2) begin
                dmin = 16'd0;
                dmax = 16'hFFFF;
                dsh = 16'hFFFF;
                gap = 16'd0;
            end else if (ph == 5) begin
                dmin = 16'd1;
                dmax = 16'd3;
                dsh = 16'd0;
                gap = 16'd4;
            end else begin
                dmin = 16'($urandom_range(1, 3));
                dmax = dmin + 16'($urandom_range(0, 3));
                dsh = dmax + 16'($urandom_range(1, 5));
                gap = ($urandom_range(0, 5) == 0) ? 16'd1 : 16'($urandom_range(2, 9));
            end
            spare = (ph == 0) ? 8'hFF : 8'($urandom_range(SPARE_INDEX, 255));
            write_reg(spare, 16'($urandom));
            write_reg(CFG_DOT_MIN, dmin);
            write_reg(CFG_DOT_MAX, dmax);
            write_reg(CFG_DASH_MAX, dsh);
            write_reg(CFG_GAP, gap);
            cfg_ch.valid <= 1'b0;

            calm = (ph == PHASES - 1);
            gaps_on = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            phase_start = sent_samples;
            while (sent_samples - phase_start < PHASE_SAMPLES) begin
                if ($urandom_range(0, 4) == 0) send_noise();
                else send_letter();
                if (!calm && $urandom_range(0, 11) == 0) drain_events();
            end
        end

        key_ch.valid <= 1'b0;
        while (expected_events.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
